[design/lome_pkg.sv]
// ----------------------------------------------------------------------------
// lome_pkg: shared types for the limit order matching engine
// Result kinds, controller states, the command and status bundles between the
// controller and the datapath, and the stored and delivered result records.
// ----------------------------------------------------------------------------
package lome_pkg;

  typedef enum logic [2:0] {
    KIND_TRADE   = 3'd0,
    KIND_FILLED  = 3'd1,
    KIND_RESTED  = 3'd2,
    KIND_DROPPED = 3'd3,
    KIND_QUERY   = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QRD,
    ST_QANS,
    ST_CHECK,
    ST_LRD,
    ST_SRD,
    ST_FILL,
    ST_SCAN,
    ST_FIN,
    ST_OWN,
    ST_DRD,
    ST_DLD
  } state_t;

  // level read select
  localparam logic LVL_OPP_BEST = 1'b0;
  localparam logic LVL_OWN      = 1'b1;

  typedef struct packed {
    logic  clr_step;
    logic  load_in;
    logic  rd_lvl;
    logic  lvl_sel;
    logic  rd_slot;
    logic  do_fill;
    logic  do_rest;
    logic  res_put;
    kind_t res_kind;
    logic  scan_step;
    logic  drain_rd;
    logic  drain_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_query;
    logic can_match;
    logic rem_zero;
    logic crosses;
    logic own_full;
    logic fill_empties;
    logic scan_done;
    logic out_free;
    logic drain_last;
  } sts_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  price;
    logic [15:0] qty;
    logic [19:0] lq;
  } res_rec_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  trade_price;
    logic [15:0] trade_quantity;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic [19:0] level_quantity;
    logic [7:0]  best_bid;
    logic [7:0]  best_ask;
    logic        bid_present;
    logic        ask_present;
    logic        last;
  } out_rec_t;

endpackage

[design/lome_in_if.sv]
// ----------------------------------------------------------------------------
// lome_in_if: order request channel
// One word per add or query request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lome_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic        side;
  logic [7:0]  price;
  logic [15:0] quantity;

  modport source (output valid, operation, side, price, quantity, input ready);
  modport sink   (input valid, operation, side, price, quantity, output ready);
endinterface

[design/lome_out_if.sv]
// ----------------------------------------------------------------------------
// lome_out_if: result channel
// One word per trade, final order status or query answer.
// ----------------------------------------------------------------------------
interface lome_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  trade_price;
  logic [15:0] trade_quantity;
  logic [31:0] buy_id;
  logic [31:0] sell_id;
  logic [19:0] level_quantity;
  logic [7:0]  best_bid;
  logic [7:0]  best_ask;
  logic        bid_present;
  logic        ask_present;
  logic        last;

  modport source (output valid, kind, trade_price, trade_quantity, buy_id, sell_id,
                  level_quantity, best_bid, best_ask, bid_present, ask_present, last,
                  input ready);
  modport sink   (input valid, kind, trade_price, trade_quantity, buy_id, sell_id,
                  level_quantity, best_bid, best_ask, bid_present, ask_present, last,
                  output ready);
endinterface

[design/lome_ctrl.sv]
// ----------------------------------------------------------------------------
// lome_ctrl: matching engine controller
// Sequences clearing, query, the fill loop, resting and the result drain.
// ----------------------------------------------------------------------------
module lome_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lome_pkg::sts_t   sts,
  output lome_pkg::cmd_t   cmd
);

  lome_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lome_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lome_pkg::ST_CLEAR: if (sts.clr_done) state_nxt = lome_pkg::ST_IDLE;
      lome_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sts.in_query ? lome_pkg::ST_QRD : lome_pkg::ST_CHECK;
      end
      lome_pkg::ST_QRD:   state_nxt = lome_pkg::ST_QANS;
      lome_pkg::ST_QANS:  state_nxt = lome_pkg::ST_DRD;
      lome_pkg::ST_CHECK: state_nxt = sts.can_match ? lome_pkg::ST_LRD : lome_pkg::ST_FIN;
      lome_pkg::ST_LRD:   state_nxt = lome_pkg::ST_SRD;
      lome_pkg::ST_SRD:   state_nxt = lome_pkg::ST_FILL;
      lome_pkg::ST_FILL:  state_nxt = sts.fill_empties ? lome_pkg::ST_SCAN : lome_pkg::ST_CHECK;
      lome_pkg::ST_SCAN:  if (sts.scan_done) state_nxt = lome_pkg::ST_CHECK;
      lome_pkg::ST_FIN: begin
        state_nxt = (sts.rem_zero || sts.crosses) ? lome_pkg::ST_DRD : lome_pkg::ST_OWN;
      end
      lome_pkg::ST_OWN:   state_nxt = lome_pkg::ST_DRD;
      lome_pkg::ST_DRD:   state_nxt = lome_pkg::ST_DLD;
      lome_pkg::ST_DLD: begin
        if (sts.out_free) state_nxt = sts.drain_last ? lome_pkg::ST_IDLE : lome_pkg::ST_DRD;
      end
      default: state_nxt = lome_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.res_kind = lome_pkg::KIND_TRADE;
    in_ready = 1'b0;
    unique case (state_r)
      lome_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      lome_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      lome_pkg::ST_QRD: begin
        cmd.rd_lvl  = 1'b1;
        cmd.lvl_sel = lome_pkg::LVL_OWN;
      end
      lome_pkg::ST_QANS: begin
        cmd.res_put  = 1'b1;
        cmd.res_kind = lome_pkg::KIND_QUERY;
      end
      lome_pkg::ST_CHECK: ;
      lome_pkg::ST_LRD: begin
        cmd.rd_lvl  = 1'b1;
        cmd.lvl_sel = lome_pkg::LVL_OPP_BEST;
      end
      lome_pkg::ST_SRD:  cmd.rd_slot   = 1'b1;
      lome_pkg::ST_FILL: cmd.do_fill   = 1'b1;
      lome_pkg::ST_SCAN: cmd.scan_step = 1'b1;
      lome_pkg::ST_FIN: begin
        priority if (sts.rem_zero) begin
          cmd.res_put  = 1'b1;
          cmd.res_kind = lome_pkg::KIND_FILLED;
        end else if (sts.crosses) begin
          cmd.res_put  = 1'b1;
          cmd.res_kind = lome_pkg::KIND_DROPPED;
        end else begin
          cmd.rd_lvl  = 1'b1;
          cmd.lvl_sel = lome_pkg::LVL_OWN;
        end
      end
      lome_pkg::ST_OWN: begin
        cmd.res_put = 1'b1;
        if (sts.own_full) begin
          cmd.res_kind = lome_pkg::KIND_DROPPED;
        end else begin
          cmd.do_rest  = 1'b1;
          cmd.res_kind = lome_pkg::KIND_RESTED;
        end
      end
      lome_pkg::ST_DRD: cmd.drain_rd = 1'b1;
      lome_pkg::ST_DLD: cmd.drain_ld = sts.out_free;
      default: ;
    endcase
  end

endmodule

[design/lome_datapath.sv]
// ----------------------------------------------------------------------------
// lome_datapath: order book storage and matching arithmetic
// Level and slot memories, best price tracking with a chunked bitmap scan,
// result buffer and output register.
// ----------------------------------------------------------------------------
module lome_datapath #(
  parameter int PRICE_LEVELS     = 256,
  parameter int ORDERS_PER_LEVEL = 16,
  parameter int QUANTITY_BITS    = 16,
  parameter int MAX_FILLS        = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lome_pkg::cmd_t      cmd,
  output lome_pkg::sts_t      sts,
  input  logic                in_operation,
  input  logic                in_side,
  input  logic [7:0]          in_price,
  input  logic [15:0]         in_quantity,
  input  logic                out_ready,
  output logic                out_valid,
  output lome_pkg::out_rec_t  out_rec
);

  localparam int PW     = $clog2(PRICE_LEVELS);
  localparam int LW     = PW + 1;
  localparam int LDEPTH = 2 * PRICE_LEVELS;
  localparam int HW     = (ORDERS_PER_LEVEL > 1) ? $clog2(ORDERS_PER_LEVEL) : 1;
  localparam int CW     = $clog2(ORDERS_PER_LEVEL + 1);
  localparam int QB     = QUANTITY_BITS;
  localparam int TW     = QB + CW;
  localparam int SW     = $clog2(PRICE_LEVELS * ORDERS_PER_LEVEL);
  localparam int SDEPTH = 2 * PRICE_LEVELS * ORDERS_PER_LEVEL;
  localparam int RW     = $clog2(MAX_FILLS + 1);
  localparam int RDEPTH = MAX_FILLS + 1;
  localparam int NCH    = (PRICE_LEVELS + 15) / 16;
  localparam int CHW    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int MW     = 16 << CHW;
  localparam int MIW    = CHW + 4;
  localparam int PSW    = ((HW > CW) ? HW : CW) + 1;

  typedef struct packed {
    logic [HW-1:0] head;
    logic [CW-1:0] cnt;
    logic [TW-1:0] tot;
  } lvl_rec_t;

  // storage
  lvl_rec_t           lvl_mem  [LDEPTH];
  logic [QB-1:0]      slot_mem [SDEPTH];
  lome_pkg::res_rec_t res_mem  [RDEPTH];

  // request and match registers
  logic               op_r, side_r;
  logic [PW-1:0]      price_r, lvl_r;
  logic [QB-1:0]      rem_r, slot_q_r;
  logic [31:0]        cnt_r, id_r;
  logic [RW-1:0]      fills_r, drain_k_r;
  lvl_rec_t           lvl_q_r;
  logic [LW-1:0]      clr_idx_r;

  // best price tracking
  logic [PW-1:0]      best_bid_r, best_ask_r;
  logic               bid_pres_r, ask_pres_r;
  logic [MW-1:0]      map_bid_r, map_ask_r;
  logic [CHW-1:0]     scan_ch_r;

  lome_pkg::res_rec_t res_q_r;
  lome_pkg::out_rec_t out_r;
  logic               out_valid_r;

  logic               opp;
  logic [PW-1:0]      price_sat, opp_best;
  logic               opp_pres, crosses, rem_zero;
  logic [QB-1:0]      tq;
  logic               fill_out;
  logic [HW-1:0]      head_nxt, rest_pos;
  logic [PSW-1:0]     pos_sum;
  logic [SW:0]        fill_addr, rest_addr;
  logic [LW-1:0]      lvl_raddr, lvl_waddr;
  lvl_rec_t           lvl_wdata;
  logic               lvl_we;
  logic [15:0]        chunk;
  logic               found, at_end;
  logic [3:0]         fidx;
  logic [MIW-1:0]     lvl_mi, price_mi;
  lome_pkg::res_rec_t res_wdata;
  logic               res_we;

  function automatic logic [SW:0] slot_addr(input logic s, input logic [PW-1:0] p,
                                            input logic [HW-1:0] pos);
    slot_addr = {s, SW'(32'(p) * ORDERS_PER_LEVEL + 32'(pos))};
  endfunction

  assign price_sat = (32'(in_price) >= 32'(PRICE_LEVELS)) ? PW'(PRICE_LEVELS - 1)
                                                          : PW'(in_price);
  assign opp       = ~side_r;
  assign opp_best  = side_r ? best_bid_r : best_ask_r;
  assign opp_pres  = side_r ? bid_pres_r : ask_pres_r;
  assign crosses   = opp_pres && (side_r ? (opp_best >= price_r) : (opp_best <= price_r));
  assign rem_zero  = (rem_r == '0);
  assign tq        = (rem_r < slot_q_r) ? rem_r : slot_q_r;
  assign fill_out  = (slot_q_r <= rem_r);
  assign head_nxt  = (lvl_q_r.head == HW'(ORDERS_PER_LEVEL - 1)) ? '0
                                                                  : lvl_q_r.head + HW'(1);
  assign pos_sum   = PSW'(lvl_q_r.head) + PSW'(lvl_q_r.cnt);
  assign rest_pos  = (pos_sum >= PSW'(ORDERS_PER_LEVEL)) ?
                     HW'(pos_sum - PSW'(ORDERS_PER_LEVEL)) : HW'(pos_sum);
  assign fill_addr = slot_addr(opp, lvl_r, lvl_q_r.head);
  assign rest_addr = slot_addr(side_r, price_r, rest_pos);
  assign lvl_mi    = MIW'(lvl_r);
  assign price_mi  = MIW'(price_r);

  assign lvl_raddr = (cmd.lvl_sel == lome_pkg::LVL_OWN) ? {side_r, price_r} : {opp, opp_best};

  // level write port: clearing pass, fill update or rest update
  always_comb begin
    lvl_we    = cmd.clr_step || cmd.do_fill || cmd.do_rest;
    lvl_waddr = clr_idx_r;
    lvl_wdata = '0;
    priority if (cmd.do_fill) begin
      lvl_waddr      = {opp, lvl_r};
      lvl_wdata.head = fill_out ? head_nxt : lvl_q_r.head;
      lvl_wdata.cnt  = fill_out ? lvl_q_r.cnt - CW'(1) : lvl_q_r.cnt;
      lvl_wdata.tot  = lvl_q_r.tot - TW'(tq);
    end else if (cmd.do_rest) begin
      lvl_waddr      = {side_r, price_r};
      lvl_wdata.head = lvl_q_r.head;
      lvl_wdata.cnt  = lvl_q_r.cnt + CW'(1);
      lvl_wdata.tot  = lvl_q_r.tot + TW'(rem_r);
    end else begin
      lvl_waddr = clr_idx_r;
    end
  end

  // bitmap chunk search: highest level for bids, lowest for asks
  always_comb begin
    chunk = opp ? map_ask_r[{scan_ch_r, 4'b0000} +: 16] : map_bid_r[{scan_ch_r, 4'b0000} +: 16];
    found = 1'b0;
    fidx  = '0;
    for (int i = 0; i < 16; i++) begin
      if (!opp) begin
        if (chunk[i]) begin
          found = 1'b1;
          fidx  = 4'(i);
        end
      end else if (chunk[15-i]) begin
        found = 1'b1;
        fidx  = 4'(15 - i);
      end
    end
    at_end = opp ? (scan_ch_r == CHW'(NCH - 1)) : (scan_ch_r == '0);
  end

  always_comb begin
    res_we    = cmd.do_fill || cmd.res_put;
    res_wdata = '0;
    if (cmd.do_fill) begin
      res_wdata.kind  = lome_pkg::KIND_TRADE;
      res_wdata.price = 8'(lvl_r);
      res_wdata.qty   = 16'(tq);
    end else if (cmd.res_kind == lome_pkg::KIND_QUERY) begin
      res_wdata.kind  = lome_pkg::KIND_QUERY;
      res_wdata.lq    = 20'(lvl_q_r.tot);
    end else begin
      res_wdata.kind  = cmd.res_kind;
      res_wdata.price = 8'(price_r);
      res_wdata.qty   = 16'(rem_r);
    end
  end

  always_comb begin
    sts.clr_done     = (clr_idx_r == LW'(LDEPTH - 1));
    sts.in_query     = in_operation;
    sts.can_match    = !rem_zero && (fills_r < RW'(MAX_FILLS)) && crosses;
    sts.rem_zero     = rem_zero;
    sts.crosses      = crosses;
    sts.own_full     = (lvl_q_r.cnt >= CW'(ORDERS_PER_LEVEL));
    sts.fill_empties = fill_out && (lvl_q_r.cnt == CW'(1));
    sts.scan_done    = found || at_end;
    sts.out_free     = !out_valid_r || out_ready;
    sts.drain_last   = (drain_k_r == fills_r);
  end

  // memories
  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[lvl_waddr] <= lvl_wdata;
    if (cmd.rd_lvl) lvl_q_r <= lvl_mem[lvl_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.do_fill) slot_mem[fill_addr] <= slot_q_r - tq;
    else if (cmd.do_rest) slot_mem[rest_addr] <= rem_r;
    if (cmd.rd_slot) slot_q_r <= slot_mem[fill_addr];
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[fills_r] <= res_wdata;
    if (cmd.drain_rd) res_q_r <= res_mem[drain_k_r];
  end

  // request payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r      <= in_operation;
      side_r    <= in_side;
      price_r   <= price_sat;
      rem_r     <= QB'(in_quantity);
      fills_r   <= '0;
      drain_k_r <= '0;
      id_r      <= cnt_r + 32'd1;
    end
    if (cmd.rd_lvl && (cmd.lvl_sel == lome_pkg::LVL_OPP_BEST)) lvl_r <= opp_best;
    if (cmd.do_fill) begin
      rem_r   <= rem_r - tq;
      fills_r <= fills_r + RW'(1);
    end
    if (cmd.drain_ld) drain_k_r <= drain_k_r + RW'(1);
  end

  // order numbers, clearing pass, book summary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      clr_idx_r  <= '0;
      best_bid_r <= '0;
      best_ask_r <= '0;
      bid_pres_r <= 1'b0;
      ask_pres_r <= 1'b0;
      map_bid_r  <= '0;
      map_ask_r  <= '0;
      scan_ch_r  <= '0;
    end else begin
      if (cmd.load_in && !in_operation) cnt_r <= cnt_r + 32'd1;
      if (cmd.clr_step && !sts.clr_done) clr_idx_r <= clr_idx_r + LW'(1);
      if (cmd.do_fill && sts.fill_empties) begin
        scan_ch_r <= lvl_mi[MIW-1:4];
        if (opp) map_ask_r[lvl_mi] <= 1'b0;
        else     map_bid_r[lvl_mi] <= 1'b0;
      end
      if (cmd.scan_step) begin
        priority if (found) begin
          if (opp) begin
            best_ask_r <= PW'({scan_ch_r, fidx});
            ask_pres_r <= 1'b1;
          end else begin
            best_bid_r <= PW'({scan_ch_r, fidx});
            bid_pres_r <= 1'b1;
          end
        end else if (at_end) begin
          if (opp) begin
            best_ask_r <= '0;
            ask_pres_r <= 1'b0;
          end else begin
            best_bid_r <= '0;
            bid_pres_r <= 1'b0;
          end
        end else begin
          scan_ch_r <= opp ? scan_ch_r + CHW'(1) : scan_ch_r - CHW'(1);
        end
      end
      if (cmd.do_rest) begin
        if (side_r) begin
          map_ask_r[price_mi] <= 1'b1;
          if (!ask_pres_r || (price_r < best_ask_r)) begin
            best_ask_r <= price_r;
            ask_pres_r <= 1'b1;
          end
        end else begin
          map_bid_r[price_mi] <= 1'b1;
          if (!bid_pres_r || (price_r > best_bid_r)) begin
            best_bid_r <= price_r;
            bid_pres_r <= 1'b1;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.drain_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_ld) begin
      out_r.kind           <= res_q_r.kind;
      out_r.trade_price    <= res_q_r.price;
      out_r.trade_quantity <= res_q_r.qty;
      out_r.level_quantity <= res_q_r.lq;
      out_r.buy_id         <= (op_r || side_r) ? 32'd0 : id_r;
      out_r.sell_id        <= (!op_r && side_r) ? id_r : 32'd0;
      out_r.best_bid       <= bid_pres_r ? 8'(best_bid_r) : 8'd0;
      out_r.best_ask       <= ask_pres_r ? 8'(best_ask_r) : 8'd0;
      out_r.bid_present    <= bid_pres_r;
      out_r.ask_present    <= ask_pres_r;
      out_r.last           <= sts.drain_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rec   = out_r;

endmodule

[design/limit_order_matching_engine.sv]
// ----------------------------------------------------------------------------
// limit_order_matching_engine: price-time priority order book
// Bid and ask books on integer price ticks, matching, resting and queries.
// ----------------------------------------------------------------------------
// Takes one request word at a time. An add numbers the order, fills it against
// the best opposite level first in, first out while prices cross, for up to
// MAX_FILLS fills, then rests or drops the remainder; a query answers the total
// resting quantity at one level. Results are buffered and sent once the step is
// done, so every word carries the best bid and ask after the whole step. After
// reset a clearing pass writes the level table with the input held off. Each
// fill reads the level, then the slot, then updates both; each time a fill
// empties the best level, a bitmap scan, chunk by chunk of 16 levels, finds
// the next best. A new request is taken while the final word still waits in
// the output register.
// ----------------------------------------------------------------------------
module limit_order_matching_engine #(
  parameter int PRICE_LEVELS     = 256,
  parameter int ORDERS_PER_LEVEL = 16,
  parameter int QUANTITY_BITS    = 16,
  parameter int MAX_FILLS        = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  lome_in_if.sink    in_word,
  lome_out_if.source out_word
);

  lome_pkg::cmd_t     cmd;
  lome_pkg::sts_t     sts;
  lome_pkg::out_rec_t out_rec;
  logic               out_valid;

  // controller: sequence each request through the datapath
  lome_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_word.valid),
    .in_ready (in_word.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: book memories, best tracking, result buffer, output register
  lome_datapath #(
    .PRICE_LEVELS     (PRICE_LEVELS),
    .ORDERS_PER_LEVEL (ORDERS_PER_LEVEL),
    .QUANTITY_BITS    (QUANTITY_BITS),
    .MAX_FILLS        (MAX_FILLS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_operation (in_word.operation),
    .in_side      (in_word.side),
    .in_price     (in_word.price),
    .in_quantity  (in_word.quantity),
    .out_ready    (out_word.ready),
    .out_valid    (out_valid),
    .out_rec      (out_rec)
  );

  // drive the result channel from the output register
  assign out_word.valid          = out_valid;
  assign out_word.kind           = out_rec.kind;
  assign out_word.trade_price    = out_rec.trade_price;
  assign out_word.trade_quantity = out_rec.trade_quantity;
  assign out_word.buy_id         = out_rec.buy_id;
  assign out_word.sell_id        = out_rec.sell_id;
  assign out_word.level_quantity = out_rec.level_quantity;
  assign out_word.best_bid       = out_rec.best_bid;
  assign out_word.best_ask       = out_rec.best_ask;
  assign out_word.bid_present    = out_rec.bid_present;
  assign out_word.ask_present    = out_rec.ask_present;
  assign out_word.last           = out_rec.last;

endmodule

[design/lome_checker.sv]
// ----------------------------------------------------------------------------
// lome_checker: port-level checks on the result channel
// Bound to the top level; watches reset, stalls and word consistency.
// ----------------------------------------------------------------------------
module lome_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [15:0] out_trade_quantity,
  input logic [31:0] out_buy_id,
  input logic [31:0] out_sell_id,
  input logic [7:0]  out_best_bid,
  input logic [7:0]  out_best_ask,
  input logic        out_bid_present,
  input logic        out_ask_present,
  input logic        out_last
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_trade_quantity) && $stable(out_last))
    else $error("stalled result word changed");

  a_query_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == lome_pkg::KIND_QUERY) |->
      out_last && (out_buy_id == 32'd0) && (out_sell_id == 32'd0))
    else $error("query answer malformed");

  a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == lome_pkg::KIND_TRADE) |->
      !out_last && ((out_buy_id == 32'd0) != (out_sell_id == 32'd0)))
    else $error("trade word ends a step or has bad ids");

  a_best_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bid_present || (out_best_bid == 8'd0)) &&
      (out_ask_present || (out_best_ask == 8'd0)))
    else $error("best price shown for an empty side");

endmodule

bind limit_order_matching_engine lome_checker u_lome_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_word.valid),
  .out_ready          (out_word.ready),
  .out_kind           (out_word.kind),
  .out_trade_quantity (out_word.trade_quantity),
  .out_buy_id         (out_word.buy_id),
  .out_sell_id        (out_word.sell_id),
  .out_best_bid       (out_word.best_bid),
  .out_best_ask       (out_word.best_ask),
  .out_bid_present    (out_word.bid_present),
  .out_ask_present    (out_word.ask_present),
  .out_last           (out_word.last)
);
